[rtl/windowed_share_rate_estimator_macros.svh]
// Assertion macros shared by the share rate estimator RTL.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef WINDOWED_SHARE_RATE_ESTIMATOR_MACROS_SVH
`define WINDOWED_SHARE_RATE_ESTIMATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define WSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/wse_pkg.sv]
// Package for the share rate estimator: widths, types and helper functions.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package wse_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int FIELD_W       = 32;
  localparam int RATE_W        = 64;
  localparam int SHARES_W      = 7;
  localparam int SUM_W         = FIELD_W + PTR_W;
  localparam int US_PER_NS_W   = 10;
  localparam int DIV_W         = FIELD_W + US_PER_NS_W;
  localparam int LO_W          = 16;
  localparam int QCNT_W        = $clog2(RATE_W);
  localparam logic [US_PER_NS_W-1:0] NS_SCALE = US_PER_NS_W'(1000);

  typedef logic [FIELD_W-1:0]  diff_t;
  typedef logic [FIELD_W-1:0]  ts_t;
  typedef logic [RATE_W-1:0]   rate_t;
  typedef logic [SHARES_W-1:0] shares_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [DIV_W-1:0]    divisor_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    diff_t wdiff;
    ts_t   wts;
    logic  re;
    ptr_t  raddr_diff;
    ptr_t  raddr_time;
  } ring_req_t;

  typedef struct packed {
    diff_t rdiff;
    ts_t   rts;
  } ring_rsp_t;

  typedef struct packed {
    logic     start;
    sum_t     sum;
    divisor_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    rate_t quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic ptr_t next_slot(input ptr_t p);
    next_slot = (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

[rtl/wse_ring.sv]
// History memories for share difficulties and timestamps, one write and one
// registered read port each. Depends on wse_pkg.
`timescale 1ns / 1ps
module wse_ring (
  input  logic              clk,
  input  wse_pkg::ring_req_t req,
  output wse_pkg::ring_rsp_t rsp
);
  import wse_pkg::*;

  diff_t diff_mem [HISTORY_DEPTH];
  ts_t   time_mem [HISTORY_DEPTH];
  diff_t rdiff_r;
  ts_t   rts_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      diff_mem[req.waddr] <= req.wdiff;
    end
    if (req.re) begin
      rdiff_r <= diff_mem[req.raddr_diff];
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      time_mem[req.waddr] <= req.wts;
    end
    if (req.re) begin
      rts_r <= time_mem[req.raddr_time];
    end
  end

  assign rsp.rdiff = rdiff_r;
  assign rsp.rts   = rts_r;

endmodule

[rtl/wse_div.sv]
// Restoring radix-2 divider for sum * 2^48 / divisor, saturating at 64 bits.
// One quotient bit per cycle. Depends on wse_pkg.
`timescale 1ns / 1ps
module wse_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wse_pkg::div_req_t req,
  output wse_pkg::div_rsp_t rsp
);
  import wse_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  divisor_t            rem_r, rem_nxt;
  divisor_t            dvs_r, dvs_nxt;
  logic [LO_W-1:0]     lo_r, lo_nxt;
  rate_t               q_r, q_nxt;
  logic [DIV_W:0]      shifted;
  logic [SUM_W-LO_W-1:0] hi;

  assign hi      = req.sum[SUM_W-1:LO_W];
  assign shifted = {rem_r, lo_r[LO_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (req.start) begin
      dvs_nxt = req.divisor;
      if (DIV_W'(hi) >= req.divisor) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = DIV_W'(hi);
        lo_nxt   = req.sum[LO_W-1:0];
        q_nxt    = '0;
        cnt_nxt  = '1;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(shifted - {1'b0, dvs_r});
        q_nxt   = {q_r[RATE_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIV_W'(shifted);
        q_nxt   = {q_r[RATE_W-2:0], 1'b0};
      end
      lo_nxt  = {lo_r[LO_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

[rtl/windowed_share_rate_estimator.sv]
// Sliding-window share rate estimator: top level with window control.
// Uses wse_pkg, wse_ring, wse_div and the assertion macro header.
//
// The input channel takes one word per accepted share: its difficulty and a
// free-running microsecond timestamp. The result channel returns one word per
// share: the rate in GH/s as unsigned Q16, the number of shares in the window,
// the window span in microseconds and a flag that says whether the rate was
// recomputed. Both channels use valid and ready.
// When the rate is recomputed, the time from acceptance to the next possible
// acceptance is set by the bit-serial divider, which forms the quotient one bit
// at a time. A zero span skips the divider, and a saturated quotient is caught
// before the bit-serial steps start. The result sits in an output register, so
// the next share is accepted while it waits; if the receiver stalls, the
// following result waits in the control logic and the input is held off until
// the output register frees up.
// Reset empties the window, clears the running sum and the held rate and drops
// any pending result. The history memories need no clearing, since only
// entries already written are used.
`timescale 1ns / 1ps
`include "windowed_share_rate_estimator_macros.svh"
module windowed_share_rate_estimator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wse_pkg::diff_t   in_share_diff,
  input  wse_pkg::ts_t     in_timestamp_us,
  output logic             out_valid,
  input  logic             out_ready,
  output wse_pkg::rate_t   out_rate_gh_q16,
  output wse_pkg::shares_t out_window_shares,
  output wse_pkg::ts_t     out_window_span_us,
  output logic             out_rate_updated
);
  import wse_pkg::*;

  state_t    state_r, state_nxt;
  ptr_t      wp_r, wp_nxt;
  ptr_t      ep_r, ep_nxt;
  logic      full_r, full_nxt;
  sum_t      sum_r, sum_nxt;
  rate_t     held_r, held_nxt;
  ptr_t      count_r, count_nxt;
  logic      evict_r, evict_nxt;
  logic      fwd_r, fwd_nxt;
  diff_t     diff_r, diff_nxt;
  ts_t       ts_r, ts_nxt;
  ts_t       span_r, span_nxt;
  logic      upd_r, upd_nxt;
  logic      ov_r, ov_nxt;
  rate_t     orate_r, orate_nxt;
  shares_t   oshares_r, oshares_nxt;
  ts_t       ospan_r, ospan_nxt;
  logic      oupd_r, oupd_nxt;
  ptr_t      ep_adv;
  logic      accept;
  ring_req_t ring_req;
  ring_rsp_t ring_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  wse_ring u_ring (
    .clk (clk),
    .req (ring_req),
    .rsp (ring_rsp)
  );

  wse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ep_adv   = full_r ? next_slot(ep_r) : ep_r;

  always_comb begin
    ring_req.we         = accept;
    ring_req.waddr      = wp_r;
    ring_req.wdiff      = in_share_diff;
    ring_req.wts        = in_timestamp_us;
    ring_req.re         = accept;
    ring_req.raddr_diff = ep_r;
    ring_req.raddr_time = ep_adv;
  end

  always_comb begin
    div_req.start   = (state_r == S_MUL) && (span_r != '0);
    div_req.sum     = sum_r;
    div_req.divisor = DIV_W'(span_r) * DIV_W'(NS_SCALE);
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    ep_nxt      = ep_r;
    full_nxt    = full_r;
    sum_nxt     = sum_r;
    held_nxt    = held_r;
    count_nxt   = count_r;
    evict_nxt   = evict_r;
    fwd_nxt     = fwd_r;
    diff_nxt    = diff_r;
    ts_nxt      = ts_r;
    span_nxt    = span_r;
    upd_nxt     = upd_r;
    ov_nxt      = ov_r;
    orate_nxt   = orate_r;
    oshares_nxt = oshares_r;
    ospan_nxt   = ospan_r;
    oupd_nxt    = oupd_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          diff_nxt  = in_share_diff;
          ts_nxt    = in_timestamp_us;
          evict_nxt = full_r;
          fwd_nxt   = (ep_adv == wp_r);
          ep_nxt    = ep_adv;
          wp_nxt    = next_slot(wp_r);
          if (full_r) begin
            count_nxt = PTR_W'(HISTORY_DEPTH - 1);
          end else begin
            count_nxt = wp_r + 1'b1;
            if (wp_r == PTR_W'(HISTORY_DEPTH - 2)) begin
              full_nxt = 1'b1;
            end
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        sum_nxt  = sum_r - (evict_r ? SUM_W'(ring_rsp.rdiff) : '0) + SUM_W'(diff_r);
        span_nxt = ts_r - (fwd_r ? ts_r : ring_rsp.rts);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (span_r == '0) begin
          upd_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          held_nxt  = div_rsp.quot;
          upd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          orate_nxt   = held_r;
          oshares_nxt = SHARES_W'(count_r);
          ospan_nxt   = span_r;
          oupd_nxt    = upd_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      ep_r    <= '0;
      full_r  <= 1'b0;
      sum_r   <= '0;
      held_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      ep_r    <= ep_nxt;
      full_r  <= full_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r   <= count_nxt;
    evict_r   <= evict_nxt;
    fwd_r     <= fwd_nxt;
    diff_r    <= diff_nxt;
    ts_r      <= ts_nxt;
    span_r    <= span_nxt;
    upd_r     <= upd_nxt;
    orate_r   <= orate_nxt;
    oshares_r <= oshares_nxt;
    ospan_r   <= ospan_nxt;
    oupd_r    <= oupd_nxt;
  end

  assign out_valid          = ov_r;
  assign out_rate_gh_q16    = orate_r;
  assign out_window_shares  = oshares_r;
  assign out_window_span_us = ospan_r;
  assign out_rate_updated   = oupd_r;

  `WSE_ASSERT_IMP(a_full_ptrs, clk, rst_n, full_r && (state_r == S_IDLE), next_slot(wp_r) == ep_r)
  `WSE_ASSERT_IMP(a_upd_span, clk, rst_n, out_valid && out_rate_updated, out_window_span_us != '0)
  `WSE_ASSERT_IMP(a_shares_nz, clk, rst_n, out_valid, out_window_shares != '0)
  `WSE_ASSERT_NXT(a_div_done, clk, rst_n, div_rsp.done, state_r == S_DONE)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the windowed share rate estimator.
// Depends on wse_pkg and windowed_share_rate_estimator; predicts each result word.
`timescale 1ns / 1ps
module tb_top;
  import wse_pkg::*;

  localparam int          WINDOW_MAX  = HISTORY_DEPTH - 1;
  localparam int unsigned US_TO_NS    = 1000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    rate_t   rate;
    shares_t shares;
    ts_t     span;
    logic    updated;
  } rate_result_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_RARE, RX_PERIODIC, RX_SLOW} rx_pattern_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  diff_t   in_share_diff = '0;
  ts_t     in_timestamp_us = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  rate_t   out_rate_gh_q16;
  shares_t out_window_shares;
  ts_t     out_window_span_us;
  logic    out_rate_updated;

  diff_t        hist_diff [HISTORY_DEPTH];
  ts_t          hist_time [HISTORY_DEPTH];
  ptr_t         slot_wr = '0;
  ptr_t         slot_old = '0;
  bit           window_full = 1'b0;
  logic [63:0]  diff_total = '0;
  rate_t        last_rate = '0;
  rate_result_t expected_results[$];
  ts_t          stamp_now;

  int unsigned mismatch_count = 0;
  int unsigned shares_sent = 0;
  int unsigned results_checked = 0;
  int unsigned held_results = 0;
  int unsigned saturated_results = 0;

  int unsigned holds_asked = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick = 0;
  rx_pattern_t rx_mode = RX_ALWAYS;

  windowed_share_rate_estimator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_share_diff     (in_share_diff),
    .in_timestamp_us   (in_timestamp_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rate_gh_q16   (out_rate_gh_q16),
    .out_window_shares (out_window_shares),
    .out_window_span_us(out_window_span_us),
    .out_rate_updated  (out_rate_updated)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TIMEOUT: run did not complete, %0d results outstanding",
             expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  function automatic void estimate_rate(input diff_t d, input ts_t t);
    rate_result_t r;
    logic [127:0] numer;
    logic [127:0] quot;
    logic [63:0]  divisor;
    ptr_t         wp;
    ptr_t         ep;
    wp = slot_wr;
    ep = slot_old;
    if (window_full) begin
      diff_total = diff_total - hist_diff[ep];
      ep = ep + 1'b1;
    end
    diff_total = diff_total + d;
    hist_diff[wp] = d;
    hist_time[wp] = t;
    r.span = hist_time[wp] - hist_time[ep];
    if (window_full) begin
      r.shares = shares_t'(WINDOW_MAX);
    end else begin
      r.shares = shares_t'(int'(wp) + 1);
      if (int'(wp) + 1 >= WINDOW_MAX) window_full = 1'b1;
    end
    r.updated = (r.span != 0);
    if (r.updated) begin
      divisor = 64'(r.span) * US_TO_NS;
      numer = 128'(diff_total) << 48;
      quot = numer / 128'(divisor);
      last_rate = (quot[127:64] != 0) ? '1 : quot[63:0];
      if (quot[127:64] != 0) saturated_results++;
    end else begin
      held_results++;
    end
    r.rate = last_rate;
    slot_wr = wp + 1'b1;
    slot_old = ep;
    expected_results.push_back(r);
  endfunction

  task automatic send_share(input diff_t d, input ts_t t);
    in_valid <= 1'b1;
    in_share_diff <= d;
    in_timestamp_us <= t;
    do @(posedge clk); while (!in_ready);
    estimate_rate(d, t);
    shares_sent++;
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void pick_share(input bit scramble, output diff_t d, output ts_t t);
    int unsigned pick;
    ts_t step;
    pick = $urandom_range(0, 9);
    if (pick == 0) d = '0;
    else if (pick == 1) d = '1;
    else if (pick <= 3) d = $urandom_range(1, 1000);
    else d = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) step = '0;
    else if (pick <= 2) step = $urandom_range(1, 16);
    else if (pick <= 6) step = $urandom_range(1, 100000);
    else if (pick <= 8) step = $urandom_range(1, 1 << 24);
    else step = $urandom_range(1, 1 << 26);
    stamp_now = stamp_now + step;
    t = stamp_now;
    if (scramble && $urandom_range(0, 3) != 0) t = $urandom;
  endfunction

  task automatic send_stream(input int unsigned count, input bit scramble);
    int unsigned sent;
    int unsigned burst;
    diff_t d;
    ts_t t;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        pick_share(scramble, d, t);
        send_share(d, t);
        sent++;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end
  endtask

  task automatic test_directed_edges();
    send_share(32'hFFFF_FFFF, 32'hFFFF_FF00);
    send_share(32'h0000_0000, 32'hFFFF_FF00);
    send_share(32'hFFFF_FFFF, 32'hFFFF_FF01);
    send_share(32'h0000_0001, 32'h0000_0010);
    send_share(32'h0000_0000, 32'hFFFF_FEFF);
    send_share(32'h0000_0000, 32'hFFFF_FF00);
    send_share(32'h0000_3039, 32'hFFFF_FF07);
    send_share(32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_full_window(input diff_t d);
    for (int k = 0; k < HISTORY_DEPTH + 2; k++) begin
      stamp_now = stamp_now + $urandom_range(1, 3);
      send_share(d, stamp_now);
    end
    wait_drained();
  endtask

  task automatic test_random_stream();
    send_stream(450, 1'b0);
    wait_drained();
    send_stream(450, 1'b0);
  endtask

  task automatic test_output_backpressure();
    diff_t d;
    ts_t t;
    holds_asked <= holds_asked + 1;
    for (int k = 0; k < 30; k++) begin
      pick_share(1'b0, d, t);
      send_share(d, t);
    end
    wait_drained();
  endtask

  task automatic test_scrambled_stamps();
    send_stream(250, 1'b1);
    wait_drained();
    send_stream(200, 1'b0);
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[7:0] == 8'd0) rx_mode <= rx_pattern_t'($urandom_range(0, 4));
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_started != holds_asked) begin
      holds_started <= holds_started + 1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_RARE: out_ready <= ($urandom_range(0, 7) != 0);
        RX_PERIODIC: out_ready <= (rx_tick[2:0] < 3'd3);
        default: out_ready <= ((rx_tick % 97) < 50);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    rate_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with none expected", out_rate_gh_q16, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_rate_gh_q16 !== want.rate)
          report_mismatch("rate_gh_q16", out_rate_gh_q16, want.rate);
        if (out_window_shares !== want.shares)
          report_mismatch("window_shares", 64'(out_window_shares), 64'(want.shares));
        if (out_window_span_us !== want.span)
          report_mismatch("window_span_us", 64'(out_window_span_us), 64'(want.span));
        if (out_rate_updated !== want.updated)
          report_mismatch("rate_updated", 64'(out_rate_updated), 64'(want.updated));
      end
    end
  end

  initial begin
    stamp_now = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_full_window('1);
    test_full_window('0);
    test_random_stream();
    test_output_backpressure();
    test_scrambled_stamps();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never returned", 64'(expected_results.size()), '0);
    $display("Summary: %0d shares sent, %0d result words checked, %0d held, %0d saturated.",
             shares_sent, results_checked, held_results, saturated_results);
    $display("Covered window fill and eviction, timer wrap, long output stall, drains.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[windowed_share_rate_estimator.f]
+incdir+rtl
rtl/wse_pkg.sv
rtl/wse_ring.sv
rtl/wse_div.sv
rtl/windowed_share_rate_estimator.sv
tb/tb_top.sv
